// File: hdl/byte_frequency_weighted_checksum_assert.svh
// Assertion macros shared by the checksum block's modules.
`ifndef BYTE_FREQUENCY_WEIGHTED_CHECKSUM_ASSERT_SVH
`define BYTE_FREQUENCY_WEIGHTED_CHECKSUM_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BFWC_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define BFWC_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/bfwc_pkg.sv
// Shared constants, types and functions of the byte frequency weighted checksum.
package bfwc_pkg;

    localparam int CTR_ENTRIES = 256;
    localparam int ADDR_W      = $clog2(CTR_ENTRIES);
    localparam int CNT_W       = 32;
    localparam int Q_DEPTH     = 2;
    localparam int Q_CNT_W     = $clog2(Q_DEPTH + 1);

    // Counter value seen by the read stage, handed from the table to the accumulator.
    typedef struct packed {
        logic             vld;
        logic             last;
        logic [CNT_W-1:0] cnt;
    } t_s1_info;

    // Start value of a counter: its byte value plus one.
    function automatic logic [CNT_W-1:0] init_count(input logic [ADDR_W-1:0] addr);
        init_count = {{(CNT_W-ADDR_W){1'b0}}, addr} + {{(CNT_W-1){1'b0}}, 1'b1};
    endfunction

endpackage

// File: hdl/bfwc_ctr_table.sv
// Per-byte-value counter table: memory, valid bits, read-modify-write and forwarding.
module bfwc_ctr_table
    import bfwc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_acc,
    input  logic [ADDR_W-1:0] i_addr,
    input  logic              i_last,
    output t_s1_info          o_s1
);

`include "byte_frequency_weighted_checksum_assert.svh"

    logic [CNT_W-1:0]       r_mem [CTR_ENTRIES];
    logic [CNT_W-1:0]       r_rd_data;
    logic                   r_s1_vld;
    logic                   r_s1_last;
    logic [ADDR_W-1:0]      r_s1_addr;
    logic [CTR_ENTRIES-1:0] r_vld_bits;
    logic                   r_fwd_vld;
    logic [ADDR_W-1:0]      r_fwd_addr;
    logic [CNT_W-1:0]       r_fwd_data;

    logic [CNT_W-1:0]       n_cnt;
    logic [CNT_W-1:0]       n_wr_data;
    logic                   n_wr_en;
    logic                   n_fwd_hit;

    // The previous item's write lands at the same edge as this item's read, so
    // its value is taken from the forwarding register instead.
    always_comb begin
        n_fwd_hit = r_fwd_vld && (r_fwd_addr == r_s1_addr);
        if (n_fwd_hit) begin
            n_cnt = r_fwd_data;
        end else if (r_vld_bits[r_s1_addr]) begin
            n_cnt = r_rd_data;
        end else begin
            n_cnt = init_count(r_s1_addr);
        end
        n_wr_data = n_cnt + {{(CNT_W-1){1'b0}}, 1'b1};
        n_wr_en   = r_s1_vld && !r_s1_last;
    end

    assign o_s1 = '{vld: r_s1_vld, last: r_s1_last, cnt: n_cnt};

    always_ff @(posedge i_clk) begin
        if (n_wr_en) begin
            r_mem[r_s1_addr] <= n_wr_data;
        end
        if (i_acc) begin
            r_rd_data <= r_mem[i_addr];
            r_s1_addr <= i_addr;
            r_s1_last <= i_last;
        end
        r_fwd_addr <= r_s1_addr;
        r_fwd_data <= n_wr_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld   <= 1'b0;
            r_vld_bits <= '0;
            r_fwd_vld  <= 1'b0;
        end else begin
            r_s1_vld  <= i_acc;
            r_fwd_vld <= n_wr_en;
            if (r_s1_vld && r_s1_last) begin
                r_vld_bits <= '0;
            end else if (n_wr_en) begin
                r_vld_bits[r_s1_addr] <= 1'b1;
            end
        end
    end

    `BFWC_ASSERT_NXT(a_last_clears_table, i_clk, i_rst_n, r_s1_vld && r_s1_last,
        r_vld_bits == '0, "table not restored after the last byte")
    `BFWC_ASSERT_NXT(a_last_kills_fwd, i_clk, i_rst_n, r_s1_vld && r_s1_last,
        !r_fwd_vld, "forwarding crosses a texture boundary")
    `BFWC_ASSERT_IMP(a_fwd_entry_valid, i_clk, i_rst_n, r_fwd_vld,
        r_vld_bits[r_fwd_addr], "forwarded entry not marked as written")

endmodule

// File: hdl/byte_frequency_weighted_checksum.sv
// Top level of the byte frequency weighted checksum.
//
// Usage: the texture's bytes arrive one transaction at a time on the input
// channel (i_valid, o_stall, i_data_byte, i_last_byte); i_last_byte marks the
// final byte. A transaction completes on an edge where i_valid is high and
// o_stall is low. One 32-bit hash leaves on the output channel (o_valid,
// i_stall, o_hash_value) per texture, after its last byte.
// Throughput is one byte per cycle while o_stall is low. The counter table is a
// 256-entry memory read at acceptance and written back in the following cycle; a
// forwarding register covers a byte that repeats the value of the byte just before it.
// The last byte's counter leaves the table's read stage, and its hash is then
// written into the output queue, from where it is offered on o_valid.
// Hashes wait in a two-entry output queue, so bytes keep flowing while a hash
// waits to be taken. o_stall rises when that queue would be full once this edge's
// push and pop are done, as when one hash waits and another is pushed while the receiver stalls.
// Reset (synchronous, active low) empties the pipeline and the queue, clears
// the running sum and marks every table entry as holding its start value; no
// clearing pass is needed, so bytes are taken in the first cycle after reset.
// The same valid-bit clear restores the table at every texture boundary.
module byte_frequency_weighted_checksum
    import bfwc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic [ADDR_W-1:0] i_data_byte,
    input  logic              i_last_byte,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [CNT_W-1:0]  o_hash_value
);

`include "byte_frequency_weighted_checksum_assert.svh"

    t_s1_info           s1;
    logic               n_acc;
    logic               n_push;
    logic               n_pop;
    logic [CNT_W-1:0]   n_sum;
    logic [Q_CNT_W-1:0] n_q_cnt;
    logic [0:0]         n_wr_idx;

    logic [CNT_W-1:0]   r_sum;
    logic [CNT_W-1:0]   r_q_data [Q_DEPTH];
    logic [Q_CNT_W-1:0] r_q_cnt;

    // The table returns, in the cycle after a byte is taken, the counter to add.
    bfwc_ctr_table u_table (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_acc   (n_acc),
        .i_addr  (i_data_byte),
        .i_last  (i_last_byte),
        .o_s1    (s1)
    );

    always_comb begin
        n_sum    = r_sum + s1.cnt;
        n_push   = s1.vld && s1.last;
        n_pop    = (r_q_cnt != '0) && !i_stall;
        n_q_cnt  = r_q_cnt + Q_CNT_W'(n_push) - Q_CNT_W'(n_pop);
        n_wr_idx = 1'(r_q_cnt - Q_CNT_W'(n_pop));
        // A byte taken now may push a hash at the next edge, so the queue must
        // keep a free slot after this edge.
        o_stall  = (n_q_cnt >= Q_CNT_W'(Q_DEPTH));
        n_acc    = i_valid && !o_stall;
    end

    assign o_valid      = (r_q_cnt != '0);
    assign o_hash_value = r_q_data[0];

    // A new hash lands in the slot behind the entries that stay after a pop.
    always_ff @(posedge i_clk) begin
        if (n_push && (n_wr_idx == 1'b0)) begin
            r_q_data[0] <= n_sum;
        end else if (n_pop) begin
            r_q_data[0] <= r_q_data[1];
        end
        if (n_push && (n_wr_idx == 1'b1)) begin
            r_q_data[1] <= n_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum   <= '0;
            r_q_cnt <= '0;
        end else begin
            r_q_cnt <= n_q_cnt;
            if (s1.vld) begin
                r_sum <= s1.last ? '0 : n_sum;
            end
        end
    end

    `BFWC_ASSERT_IMP(a_queue_bound, i_clk, i_rst_n, 1'b1,
        r_q_cnt <= Q_CNT_W'(Q_DEPTH), "output queue holds too many hashes")
    `BFWC_ASSERT_IMP(a_push_has_room, i_clk, i_rst_n, n_push,
        (r_q_cnt != Q_CNT_W'(Q_DEPTH)) || n_pop, "hash pushed into a full queue")
    `BFWC_ASSERT_NXT(a_sum_restart, i_clk, i_rst_n, s1.vld && s1.last,
        r_sum == '0, "running sum not cleared after the last byte")

endmodule

// File: bench/byte_frequency_weighted_checksum_test.sv
// Self-checking testbench for the byte frequency weighted checksum block.
`timescale 1ns / 1ps

module byte_frequency_weighted_checksum_test;
    import bfwc_pkg::*;

    // The run is cut off here if the hashes stop coming. The slowest correct run
    // is a single-byte texture per item, every item after the longest sender gap
    // and every hash after the longest receiver stall, and this limit leaves a wide
    // margin even for that.
    localparam int CYCLE_LIMIT = 200000;
    localparam int RANDOM_BYTES = 450;
    localparam int MAX_IDLE = 11;
    // Extra wait after the final drain, before the result is judged.
    localparam int SETTLE_CYCLES = 8;

    // Keeps its own copy of the counter table and the running sum, and holds
    // the hashes that are due, oldest first.
    class hash_board;
        bit [CNT_W-1:0] counts[CTR_ENTRIES];
        bit [CNT_W-1:0] sum;
        bit [CNT_W-1:0] due_hashes[$];
        int             errors;

        function new();
            errors = 0;
            restart();
        endfunction

        // Every texture starts from a table where the entry for value v holds v+1.
        function void restart();
            foreach (counts[v]) counts[v] = v + 1;
            sum = '0;
        endfunction

        // Called for each accepted byte transaction.
        function void note_byte(bit [ADDR_W-1:0] value, bit last);
            sum += counts[value];
            counts[value] += 1;
            if (last) begin
                due_hashes.push_back(sum);
                restart();
            end
        endfunction

        // Called for each accepted hash transaction.
        function void check_hash(bit [CNT_W-1:0] got);
            bit [CNT_W-1:0] want;
            if (due_hashes.size() == 0) begin
                $display("%0t: hash %08h arrived with none due", $time, got);
                errors++;
            end else begin
                want = due_hashes.pop_front();
                if (got !== want) begin
                    $display("%0t: hash_value expected %08h actual %08h", $time, want, got);
                    errors++;
                end
            end
        endfunction
    endclass

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_valid = 1'b0;
    logic              o_stall;
    logic [ADDR_W-1:0] i_data_byte = '0;
    logic              i_last_byte = 1'b0;
    logic              o_valid;
    logic              i_stall = 1'b0;
    logic [CNT_W-1:0]  o_hash_value;

    hash_board board = new();

    // Idle ranges for both sides; phases of the run narrow or widen them.
    int unsigned send_gap_max = MAX_IDLE;
    int unsigned stall_lo = 0;
    int unsigned stall_hi = MAX_IDLE;
    int unsigned stall_left = 0;
    int unsigned cycles = 0;
    int unsigned bytes_sent = 0;

    byte_frequency_weighted_checksum uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_data_byte  (i_data_byte),
        .i_last_byte  (i_last_byte),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_hash_value (o_hash_value)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // Watchdog: a block that hangs or drops a hash ends the run here.
    always @(posedge i_clk) begin
        cycles++;
        if (cycles == CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Hash receiver. After each accepted hash it draws how many cycles to hold
    // i_stall high, so stalls land before, during and after o_valid rises.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            stall_left = 0;
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                board.check_hash(o_hash_value);
                stall_left = $urandom_range(stall_hi, stall_lo);
            end else if (stall_left != 0) begin
                stall_left--;
            end
            i_stall <= (stall_left != 0);
        end
    end

    // Offers one byte and returns at the edge where it is accepted. With a zero
    // gap, i_valid simply stays high and the payload changes at that edge.
    task automatic send_byte(input bit [ADDR_W-1:0] value, input bit last);
        int unsigned gap;
        gap = $urandom_range(send_gap_max, 0);
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_data_byte <= value;
        i_last_byte <= last;
        do @(posedge i_clk); while (o_stall);
        board.note_byte(value, last);
        bytes_sent++;
    endtask

    // Lowers i_valid after the last accepted byte, then waits until every due
    // hash has been taken. At least one edge passes, so i_valid is never
    // assigned twice in one time step.
    task automatic drain_hashes();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (board.due_hashes.size() != 0);
    endtask

    // Sends one texture of random bytes. Narrow alphabets make repeated and
    // back-to-back equal values common, which is what the table's forwarding
    // path has to get right.
    task automatic send_texture(input int unsigned len, input int unsigned alphabet);
        bit [ADDR_W-1:0] base;
        base = ADDR_W'($urandom);
        for (int unsigned k = 0; k < len; k++)
            send_byte(ADDR_W'(base + $urandom_range(alphabet - 1, 0)), k == len - 1);
    endtask

    initial begin
        int unsigned style;
        int unsigned len;
        bit          mid_pause_done;

        mid_pause_done = 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed textures. The smallest and largest byte values alone hash to
        // their start counts; a byte that repeats at once exercises forwarding;
        // back-to-back single-byte textures check that the table is restored.
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b1);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b1);
        repeat (3) send_byte(8'h07, 1'b0);
        send_byte(8'h07, 1'b1);
        send_byte(8'h01, 1'b0);
        send_byte(8'h02, 1'b0);
        send_byte(8'h01, 1'b0);
        send_byte(8'h02, 1'b1);
        for (int k = 0; k < 5; k++)
            send_byte((k % 2 == 0) ? 8'hFF : 8'h00, k == 4);
        send_byte(8'h55, 1'b0);
        send_byte(8'hAA, 1'b1);
        send_byte(8'h03, 1'b1);
        send_byte(8'h03, 1'b1);

        // Pause the sender until every hash of the directed part has come.
        drain_hashes();

        bytes_sent = 0;
        while (bytes_sent < RANDOM_BYTES) begin
            // Every so often switch the idling pattern: full random idling, no
            // idling on either side, or a receiver that always stalls as long as
            // it can while single-byte textures arrive back to back, which is
            // what fills the output queue and makes o_stall rise.
            style = $urandom_range(9, 0);
            if (style < 5) begin
                send_gap_max = MAX_IDLE;
                stall_lo = 0;
                stall_hi = MAX_IDLE;
            end else if (style < 8) begin
                send_gap_max = 0;
                stall_lo = 0;
                stall_hi = 0;
            end else begin
                send_gap_max = 0;
                stall_lo = MAX_IDLE;
                stall_hi = MAX_IDLE;
                repeat (8) send_byte(ADDR_W'($urandom), 1'b1);
                continue;
            end

            repeat (6) begin
                style = $urandom_range(99, 0);
                if (style < 60) begin
                    len = $urandom_range(12, 1);
                    send_texture(len, CTR_ENTRIES);
                end else if (style < 85) begin
                    len = $urandom_range(16, 2);
                    send_texture(len, $urandom_range(4, 1));
                end else begin
                    send_byte(ADDR_W'($urandom), 1'b1);
                end
            end

            // One more pause partway through the random part.
            if (!mid_pause_done && bytes_sent >= RANDOM_BYTES / 2) begin
                drain_hashes();
                mid_pause_done = 1'b1;
            end
        end

        drain_hashes();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (board.errors == 0 && board.due_hashes.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

// File: filelist.f
+incdir+hdl
hdl/bfwc_pkg.sv
hdl/bfwc_ctr_table.sv
hdl/byte_frequency_weighted_checksum.sv
bench/byte_frequency_weighted_checksum_test.sv
